// ===== hdl/dltq_pkg.sv =====
// Package for the delta list timer queue core.
// Holds request codes, result kinds and the fixed field widths.
// No dependencies.
package dltq_pkg;

   localparam int TIME_W = 64;
   localparam int ARG_W  = 32;
   localparam int MS_W   = 32;

   // request codes carried in req_tuser
   localparam logic [1:0] REQ_ADD  = 2'd0;
   localparam logic [1:0] REQ_DEL  = 2'd1;
   localparam logic [1:0] REQ_POLL = 2'd2;

   // result kinds carried in rsp_tuser
   localparam logic [1:0] KIND_ACK    = 2'd0;
   localparam logic [1:0] KIND_EXPIRY = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

endpackage

// ===== hdl/delta_list_timer_queue_core.sv =====
// Delta list timer queue core: sequencer over a slot entry memory and an argument memory.
// Steps: an add converts the timeout, forms the deadline, walks from the head and links the entry;
// a delete unlinks its entry; a poll expires head entries in turn, then reports the ticks left;
// refused or unknown words go straight to the result; a stalled result word holds the core.
// Throughput: one word at a time; the next word is taken once the last result is registered.
// Reset (synchronous) clears the sequencer, head, tail, count and queued flags and sets
// ticks_per_ms to 1000; the memories keep no reset and are written before being read.
module delta_list_timer_queue_core
   import dltq_pkg::*;
#(
   parameter int NUM_SLOTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_tdata: slot_id[3:0], timeout_ms[35:4], timer_arg[67:36], current_time[131:68]
   input  logic [135:0] req_tdata,
   // req_tuser: req_type[1:0]
   input  logic [1:0]   req_tuser,
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rsp_tdata: expired_slot[3:0], expired_arg[35:4], kick[36], error_flag[37],
   //            queue_empty[38], ticks_left[102:39], zero[103]
   output logic [103:0] rsp_tdata,
   // rsp_tuser: result_kind[1:0]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   // configuration
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);

   localparam int IDX_W  = $clog2(NUM_SLOTS);
   localparam int LINK_W = $clog2(NUM_SLOTS + 1);
   localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_SLOTS);

   typedef struct packed {
      logic [TIME_W-1:0] delta;
      logic [LINK_W-1:0] next;
      logic [LINK_W-1:0] prev;
   } entry_type;

   typedef struct packed {
      logic              delta_we;
      logic              next_we;
      logic              prev_we;
      logic [IDX_W-1:0]  idx;
      entry_type         data;
   } mem_wr_type;

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_MUL   = 16'h0002,
      S_WHEN  = 16'h0004,
      S_HEAD  = 16'h0008,
      S_WALK  = 16'h0010,
      S_WDATA = 16'h0020,
      S_L1    = 16'h0040,
      S_L2    = 16'h0080,
      S_L3    = 16'h0100,
      S_UREAD = 16'h0200,
      S_UDATA = 16'h0400,
      S_UNEXT = 16'h0800,
      S_UPREV = 16'h1000,
      S_PREAD = 16'h2000,
      S_PDATA = 16'h4000,
      S_EMIT  = 16'h8000
   } state_type;

   // memories
   entry_type        ent_mem [NUM_SLOTS];
   logic [ARG_W-1:0] arg_mem [NUM_SLOTS];
   entry_type        ent_rd_ff;
   logic [ARG_W-1:0] arg_rd_ff;

   // control state
   state_type           state_ff, state_in;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [LINK_W-1:0]   tail_ff, tail_in;
   logic [LINK_W-1:0]   count_ff, count_in;
   logic [NUM_SLOTS-1:0] queued_ff, queued_in;
   logic [31:0]         tpm_ff;
   logic                op_poll_ff, op_poll_in;
   logic                rsp_valid_ff;

   // request and work registers
   logic [3:0]          req_slot_ff, req_slot_in;
   logic [MS_W-1:0]     req_ms_ff, req_ms_in;
   logic [ARG_W-1:0]    req_arg_ff, req_arg_in;
   logic [TIME_W-1:0]   req_now_ff, req_now_in;
   logic [TIME_W-1:0]   prod_ff, prod_in;
   logic [TIME_W-1:0]   rem_ff, rem_in;
   logic [LINK_W-1:0]   cur_ff, cur_in;
   logic [LINK_W-1:0]   at_ff, at_in;
   logic [LINK_W-1:0]   p_ff, p_in;
   logic [TIME_W-1:0]   atd_ff, atd_in;
   logic                atd_we_ff, atd_we_in;
   logic [LINK_W-1:0]   u_slot_ff, u_slot_in;
   logic [TIME_W-1:0]   sd_ff, sd_in;
   logic [LINK_W-1:0]   sn_ff, sn_in;
   logic [LINK_W-1:0]   sp_ff, sp_in;

   // pending result
   logic [1:0]          pend_kind_ff, pend_kind_in;
   logic [3:0]          pend_slot_ff, pend_slot_in;
   logic [ARG_W-1:0]    pend_arg_ff, pend_arg_in;
   logic                pend_kick_ff, pend_kick_in;
   logic                pend_err_ff, pend_err_in;
   logic [TIME_W-1:0]   pend_left_ff, pend_left_in;
   logic                pend_last_ff, pend_last_in;

   // output registers
   logic [103:0]        rsp_data_ff;
   logic [1:0]          rsp_user_ff;
   logic                rsp_last_ff;

   // memory controls
   mem_wr_type          wr;
   logic                arg_we;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_idx;
   logic                load_rsp;
   logic                out_free;

   // decoded input word
   logic [3:0]          in_slot;
   logic [MS_W-1:0]     in_ms;
   logic                in_ok;
   logic [IDX_W-1:0]    in_idx;
   logic [LINK_W-1:0]   in_link;
   logic [IDX_W-1:0]    s_idx;
   logic [LINK_W-1:0]   s_link;
   logic [TIME_W:0]     when_sum;

   function automatic logic is_slot(input logic [LINK_W-1:0] l);
      return l < NIL;
   endfunction

   function automatic logic [IDX_W-1:0] to_idx(input logic [LINK_W-1:0] l);
      return l[IDX_W-1:0];
   endfunction

   assign in_slot  = req_tdata[3:0];
   assign in_ms    = req_tdata[35:4];
   assign in_ok    = (32'(in_slot) < NUM_SLOTS);
   assign in_idx   = IDX_W'(in_slot);
   assign in_link  = LINK_W'(in_idx);
   assign s_idx    = IDX_W'(req_slot_ff);
   assign s_link   = LINK_W'(s_idx);
   assign when_sum = {1'b0, prod_ff} + {1'b0, req_now_ff};
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      queued_in    = queued_ff;
      op_poll_in   = op_poll_ff;
      req_slot_in  = req_slot_ff;
      req_ms_in    = req_ms_ff;
      req_arg_in   = req_arg_ff;
      req_now_in   = req_now_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      cur_in       = cur_ff;
      at_in        = at_ff;
      p_in         = p_ff;
      atd_in       = atd_ff;
      atd_we_in    = atd_we_ff;
      u_slot_in    = u_slot_ff;
      sd_in        = sd_ff;
      sn_in        = sn_ff;
      sp_in        = sp_ff;
      pend_kind_in = pend_kind_ff;
      pend_slot_in = pend_slot_ff;
      pend_arg_in  = pend_arg_ff;
      pend_kick_in = pend_kick_ff;
      pend_err_in  = pend_err_ff;
      pend_left_in = pend_left_ff;
      pend_last_in = pend_last_ff;
      wr           = '0;
      arg_we       = 1'b0;
      rd_en        = 1'b0;
      rd_idx       = to_idx(head_ff);
      load_rsp     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               req_slot_in  = in_slot;
               req_ms_in    = in_ms;
               req_arg_in   = req_tdata[67:36];
               req_now_in   = req_tdata[131:68];
               pend_kind_in = KIND_ACK;
               pend_slot_in = '0;
               pend_arg_in  = '0;
               pend_kick_in = 1'b0;
               pend_err_in  = 1'b0;
               pend_left_in = '0;
               pend_last_in = 1'b1;
               state_in     = S_EMIT;
               case (req_tuser)
                  REQ_ADD: begin
                     if (in_ok && !queued_ff[in_idx] && in_ms != '0 && in_ms != '1) begin
                        state_in = S_MUL;
                     end else begin
                        pend_err_in = 1'b1;
                     end
                  end
                  REQ_DEL: begin
                     if (in_ok && queued_ff[in_idx]) begin
                        u_slot_in    = in_link;
                        pend_kick_in = (head_ff == in_link);
                        op_poll_in   = 1'b0;
                        state_in     = S_UREAD;
                     end
                  end
                  REQ_POLL: begin
                     op_poll_in = 1'b1;
                     state_in   = S_PREAD;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end

         // convert timeout, store argument, fetch head
         S_MUL: begin
            prod_in  = 64'(req_ms_ff) * 64'(tpm_ff);
            arg_we   = 1'b1;
            rd_en    = is_slot(head_ff);
            state_in = S_WHEN;
         end

         // absolute deadline, saturated
         S_WHEN: begin
            rem_in   = when_sum[TIME_W] ? '1 : when_sum[TIME_W-1:0];
            state_in = S_HEAD;
         end

         // place against the head
         S_HEAD: begin
            if (!is_slot(head_ff)) begin
               at_in        = NIL;
               p_in         = tail_ff;
               atd_we_in    = 1'b0;
               pend_kick_in = 1'b1;
               state_in     = S_L1;
            end else if (ent_rd_ff.delta > rem_ff) begin
               at_in        = head_ff;
               p_in         = ent_rd_ff.prev;
               atd_in       = ent_rd_ff.delta - rem_ff;
               atd_we_in    = 1'b1;
               pend_kick_in = 1'b1;
               state_in     = S_L1;
            end else begin
               rem_in   = rem_ff - ent_rd_ff.delta;
               cur_in   = ent_rd_ff.next;
               state_in = S_WALK;
            end
         end

         // fetch the next entry of the walk
         S_WALK: begin
            if (!is_slot(cur_ff)) begin
               at_in     = NIL;
               p_in      = tail_ff;
               atd_we_in = 1'b0;
               state_in  = S_L1;
            end else begin
               rd_en    = 1'b1;
               rd_idx   = to_idx(cur_ff);
               state_in = S_WDATA;
            end
         end

         // stop before an entry whose delta covers the remainder
         S_WDATA: begin
            if (ent_rd_ff.delta >= rem_ff) begin
               at_in     = cur_ff;
               p_in      = ent_rd_ff.prev;
               atd_in    = ent_rd_ff.delta - rem_ff;
               atd_we_in = 1'b1;
               state_in  = S_L1;
            end else begin
               rem_in   = rem_ff - ent_rd_ff.delta;
               cur_in   = ent_rd_ff.next;
               state_in = S_WALK;
            end
         end

         // write the new entry
         S_L1: begin
            wr.delta_we   = 1'b1;
            wr.next_we    = 1'b1;
            wr.prev_we    = 1'b1;
            wr.idx        = s_idx;
            wr.data.delta = rem_ff;
            wr.data.next  = at_ff;
            wr.data.prev  = p_ff;
            state_in      = S_L2;
         end

         // relink the successor and shrink its delta
         S_L2: begin
            if (is_slot(at_ff)) begin
               wr.prev_we    = 1'b1;
               wr.delta_we   = atd_we_ff;
               wr.idx        = to_idx(at_ff);
               wr.data.prev  = s_link;
               wr.data.delta = atd_ff;
            end
            state_in = S_L3;
         end

         // relink the predecessor or the head
         S_L3: begin
            if (is_slot(p_ff)) begin
               wr.next_we   = 1'b1;
               wr.idx       = to_idx(p_ff);
               wr.data.next = s_link;
            end else begin
               head_in = s_link;
            end
            if (!is_slot(at_ff)) begin
               tail_in = s_link;
            end
            queued_in[s_idx] = 1'b1;
            count_in         = count_ff + 1'b1;
            state_in         = S_EMIT;
         end

         // unlink: fetch the entry
         S_UREAD: begin
            rd_en    = 1'b1;
            rd_idx   = to_idx(u_slot_ff);
            state_in = S_UDATA;
         end

         // unlink: hold the entry, fetch the successor
         S_UDATA: begin
            sd_in = ent_rd_ff.delta;
            sn_in = ent_rd_ff.next;
            sp_in = ent_rd_ff.prev;
            if (op_poll_ff) begin
               pend_kind_in = KIND_EXPIRY;
               pend_slot_in = 4'(u_slot_ff);
               pend_arg_in  = arg_rd_ff;
               pend_kick_in = 1'b0;
               pend_err_in  = 1'b0;
               pend_left_in = '0;
               pend_last_in = 1'b0;
            end
            if (is_slot(ent_rd_ff.next)) begin
               rd_en    = 1'b1;
               rd_idx   = to_idx(ent_rd_ff.next);
               state_in = S_UNEXT;
            end else begin
               tail_in  = ent_rd_ff.prev;
               state_in = S_UPREV;
            end
         end

         // unlink: fold the delta into the successor
         S_UNEXT: begin
            wr.delta_we   = 1'b1;
            wr.prev_we    = 1'b1;
            wr.idx        = to_idx(sn_ff);
            wr.data.delta = ent_rd_ff.delta + sd_ff;
            wr.data.prev  = sp_ff;
            state_in      = S_UPREV;
         end

         // unlink: relink the predecessor or the head
         S_UPREV: begin
            if (is_slot(sp_ff)) begin
               wr.next_we   = 1'b1;
               wr.idx       = to_idx(sp_ff);
               wr.data.next = sn_ff;
            end else begin
               head_in = sn_ff;
            end
            queued_in[to_idx(u_slot_ff)] = 1'b0;
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
            state_in = S_EMIT;
         end

         // poll: fetch the head
         S_PREAD: begin
            if (is_slot(head_ff)) begin
               rd_en    = 1'b1;
               state_in = S_PDATA;
            end else begin
               pend_kind_in = KIND_STATUS;
               pend_slot_in = '0;
               pend_arg_in  = '0;
               pend_kick_in = 1'b0;
               pend_err_in  = 1'b0;
               pend_left_in = '0;
               pend_last_in = 1'b1;
               state_in     = S_EMIT;
            end
         end

         // poll: expire the head or report the ticks left
         S_PDATA: begin
            if (req_now_ff >= ent_rd_ff.delta) begin
               u_slot_in = head_ff;
               state_in  = S_UDATA;
            end else begin
               pend_kind_in = KIND_STATUS;
               pend_slot_in = '0;
               pend_arg_in  = '0;
               pend_kick_in = 1'b0;
               pend_err_in  = 1'b0;
               pend_left_in = ent_rd_ff.delta - req_now_ff;
               pend_last_in = 1'b1;
               state_in     = S_EMIT;
            end
         end

         // hand the result word to the output register
         S_EMIT: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = pend_last_ff ? S_IDLE : S_PREAD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         head_ff    <= NIL;
         tail_ff    <= NIL;
         count_ff   <= '0;
         queued_ff  <= '0;
         op_poll_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         queued_ff  <= queued_in;
         op_poll_ff <= op_poll_in;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         tpm_ff <= 32'd1000;
      end else if (csr_wr_en) begin
         tpm_ff <= csr_wr_data;
      end
   end

   // work and pending registers
   always_ff @(posedge clock) begin
      req_slot_ff  <= req_slot_in;
      req_ms_ff    <= req_ms_in;
      req_arg_ff   <= req_arg_in;
      req_now_ff   <= req_now_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      cur_ff       <= cur_in;
      at_ff        <= at_in;
      p_ff         <= p_in;
      atd_ff       <= atd_in;
      atd_we_ff    <= atd_we_in;
      u_slot_ff    <= u_slot_in;
      sd_ff        <= sd_in;
      sn_ff        <= sn_in;
      sp_ff        <= sp_in;
      pend_kind_ff <= pend_kind_in;
      pend_slot_ff <= pend_slot_in;
      pend_arg_ff  <= pend_arg_in;
      pend_kick_ff <= pend_kick_in;
      pend_err_ff  <= pend_err_in;
      pend_left_ff <= pend_left_in;
      pend_last_ff <= pend_last_in;
   end

   // entry memory: field write enables, registered read
   always_ff @(posedge clock) begin
      if (wr.delta_we) begin
         ent_mem[wr.idx].delta <= wr.data.delta;
      end
      if (wr.next_we) begin
         ent_mem[wr.idx].next <= wr.data.next;
      end
      if (wr.prev_we) begin
         ent_mem[wr.idx].prev <= wr.data.prev;
      end
      if (rd_en) begin
         ent_rd_ff <= ent_mem[rd_idx];
      end
   end

   // argument memory
   always_ff @(posedge clock) begin
      if (arg_we) begin
         arg_mem[s_idx] <= req_arg_ff;
      end
      if (rd_en) begin
         arg_rd_ff <= arg_mem[rd_idx];
      end
   end

   // output register: load a word, drop valid when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= {1'b0, pend_left_ff, (count_ff == '0), pend_err_ff, pend_kick_ff,
                         pend_arg_ff, pend_slot_ff};
         rsp_user_ff <= pend_kind_ff;
         rsp_last_ff <= pend_last_ff;
      end
   end

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= NUM_SLOTS)
      else $error("queued count above slot count");

   a_count_flags: assert property (@(posedge clock) disable iff (reset)
      32'($countones(queued_ff)) == 32'(count_ff))
      else $error("queued flags disagree with count");

   a_head_empty: assert property (@(posedge clock) disable iff (reset)
      (head_ff == NIL) == (count_ff == '0))
      else $error("head null does not match empty queue");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff)
      else $error("loaded result word not valid");

endmodule
